// File: rtl/fsba_pkg.sv
// Shared types and constants for the free-slot bitmap allocator.
package fsba_pkg;

	localparam int SLOT_W   = 12;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 7;

	localparam int MAP_WORDS_DEF = 64;
	localparam int WORD_BITS_DEF = 64;

	localparam logic [CFG_W-1:0] WORDS_IN_USE_RST = 7'd64;

	// hint / WORD_BITS is done as a multiply by a rounded-up reciprocal
	localparam int DIV_SHIFT = 24;
	localparam int RECIP_W   = 22;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic clr_wr;
		logic hint_ld;
		logic mul_en;
		logic idx_en;
		logic mod_en;
		logic hit_wr;
		logic scan_start;
		logic scan_step;
		logic found_ld;
		logic grant_wr;
		logic res_full;
		logic res_range;
		logic out_ld;
	} fsba_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hint_oor;
		logic hint_free;
		logic word_free;
		logic scan_last;
		logic out_free;
	} fsba_sts_t;

endpackage

// File: rtl/fsba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/fsba_ctrl.sv
// Controller state machine of the free-slot bitmap allocator.
module fsba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fsba_pkg::fsba_sts_t sts,
	output fsba_pkg::fsba_cmd_t cmd
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MUL   = 4'd2;
	localparam logic [3:0] S_IDX   = 4'd3;
	localparam logic [3:0] S_MOD   = 4'd4;
	localparam logic [3:0] S_HCHK  = 4'd5;
	localparam logic [3:0] S_SCAN  = 4'd6;
	localparam logic [3:0] S_GRANT = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.hint_ld = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_IDX;
			end
			S_IDX: begin
				cmd.idx_en = 1'b1;
				state_d    = S_MOD;
			end
			S_MOD: begin
				cmd.mod_en = 1'b1;
				if (sts.hint_oor) begin
					cmd.res_range = 1'b1;
					state_d       = S_FIN;
				end else begin
					state_d = S_HCHK;
				end
			end
			S_HCHK: begin
				if (sts.hint_free) begin
					cmd.hit_wr = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.word_free) begin
					cmd.found_ld = 1'b1;
					state_d      = S_GRANT;
				end else if (sts.scan_last) begin
					cmd.res_full = 1'b1;
					state_d      = S_FIN;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_GRANT: begin
				cmd.grant_wr = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/fsba_dp.sv
// Datapath of the free-slot bitmap allocator: index math, bitmap RAM, result.
module fsba_dp #(
	parameter int MAP_WORDS = fsba_pkg::MAP_WORDS_DEF,
	parameter int WORD_BITS = fsba_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fsba_pkg::SLOT_W-1:0]     hint_slot,
	input  logic                            cfg_we,
	input  logic [fsba_pkg::CFG_W-1:0]      cfg_wdata,
	output logic [fsba_pkg::SLOT_W-1:0]     granted_slot,
	output logic [fsba_pkg::STATUS_W-1:0]   status,
	output logic                            out_valid,
	input  logic                            out_stall,
	input  fsba_pkg::fsba_cmd_t             cmd,
	output fsba_pkg::fsba_sts_t             sts
);

	localparam int SW     = fsba_pkg::SLOT_W;
	localparam int CW     = fsba_pkg::CFG_W;
	localparam int PW     = SW + fsba_pkg::RECIP_W;
	localparam int AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW     = $clog2(WORD_BITS);
	localparam int NW_CAP = (MAP_WORDS > (1 << CW) - 1) ? (1 << CW) - 1 : MAP_WORDS;
	localparam logic [CW-1:0] NW_MAX = CW'(NW_CAP);
	localparam logic [fsba_pkg::RECIP_W-1:0] RECIP =
		fsba_pkg::RECIP_W'(((1 << fsba_pkg::DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS);
	localparam logic [AW-1:0] CLR_LAST = AW'(MAP_WORDS - 1);

	logic [CW-1:0]                 wiu_q;
	logic [AW-1:0]                 clr_q;
	logic [SW-1:0]                 hint_q;
	logic [PW-1:0]                 prod_q;
	logic [SW-1:0]                 hw_q;
	logic [BW-1:0]                 hb_q;
	logic [CW-1:0]                 w_q;
	logic [WORD_BITS-1:0]          word_q;
	logic [BW-1:0]                 bit_q;
	logic [SW-1:0]                 res_slot_q;
	logic [fsba_pkg::STATUS_W-1:0] res_status_q;
	logic                          out_valid_q;
	logic [SW-1:0]                 granted_slot_q;
	logic [fsba_pkg::STATUS_W-1:0] status_q;

	logic [CW-1:0]        nw;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] free_bits;
	logic [BW-1:0]        low_bit;
	logic [SW:0]          grant_sum;
	logic [SW-1:0]        hw_base;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [AW-1:0]        ram_raddr;

	// a register value of zero acts as one; clamp to the map depth
	always_comb begin
		if (wiu_q == '0) begin
			nw = CW'(1);
		end else if (wiu_q > NW_MAX) begin
			nw = NW_MAX;
		end else begin
			nw = wiu_q;
		end
	end

	assign free_bits = ~rdata;
	assign hw_base   = SW'(hw_q * SW'(WORD_BITS));
	assign grant_sum = (SW + 1)'(w_q) * (SW + 1)'(WORD_BITS) + (SW + 1)'(bit_q);

	always_comb begin
		low_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				low_bit = BW'(i);
			end
		end
	end

	always_comb begin
		sts.clr_last  = (clr_q == CLR_LAST);
		sts.hint_oor  = (hw_q >= SW'(nw));
		sts.hint_free = !rdata[hb_q];
		sts.word_free = |free_bits;
		sts.scan_last = (w_q == nw - CW'(1));
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// RAM port selection
	always_comb begin
		if (cmd.mod_en) begin
			ram_raddr = AW'(hw_q);
		end else if (cmd.scan_step) begin
			ram_raddr = AW'(w_q + CW'(1));
		end else begin
			ram_raddr = '0;
		end

		ram_we    = cmd.clr_wr || cmd.hit_wr || cmd.grant_wr;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (cmd.hit_wr) begin
			ram_waddr = AW'(hw_q);
			ram_wdata = rdata | (WORD_BITS'(1) << hb_q);
		end else if (cmd.grant_wr) begin
			ram_waddr = AW'(w_q);
			ram_wdata = word_q | (WORD_BITS'(1) << bit_q);
		end
	end

	fsba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q       <= fsba_pkg::WORDS_IN_USE_RST;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wiu_q <= cfg_wdata;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hint_ld) begin
			hint_q <= hint_slot;
		end
		if (cmd.mul_en) begin
			prod_q <= PW'(hint_q) * PW'(RECIP);
		end
		if (cmd.idx_en) begin
			hw_q <= SW'(prod_q[PW-1:fsba_pkg::DIV_SHIFT]);
		end
		if (cmd.mod_en) begin
			hb_q <= BW'(hint_q - hw_base);
		end
		if (cmd.scan_start) begin
			w_q <= '0;
		end else if (cmd.scan_step) begin
			w_q <= w_q + CW'(1);
		end
		if (cmd.found_ld) begin
			word_q <= rdata;
			bit_q  <= low_bit;
		end
		if (cmd.hit_wr) begin
			res_slot_q   <= hint_q;
			res_status_q <= fsba_pkg::STATUS_OK;
		end else if (cmd.grant_wr) begin
			res_slot_q   <= grant_sum[SW-1:0];
			res_status_q <= fsba_pkg::STATUS_OK;
		end else if (cmd.res_full) begin
			res_slot_q   <= '0;
			res_status_q <= fsba_pkg::STATUS_FULL;
		end else if (cmd.res_range) begin
			res_slot_q   <= '0;
			res_status_q <= fsba_pkg::STATUS_RANGE;
		end
		if (cmd.out_ld) begin
			granted_slot_q <= res_slot_q;
			status_q       <= res_status_q;
		end
	end

	assign granted_slot = granted_slot_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;

endmodule

// File: rtl/free_slot_bitmap_allocator.sv
// Top level of the free-slot bitmap allocator with hint.
//
// Input channel: hint_slot with in_valid / in_stall; a transfer happens at a
// rising edge with in_valid high and in_stall low. Output channel:
// granted_slot and status with out_valid / out_stall, same rule.
// Status is 0 for a grant, 1 when every slot in use is taken, and 2 when the
// hint is not below words_in_use*WORD_BITS; granted_slot is 0 unless status 0.
// The user is to load the words_in_use register by cfg_we / cfg_wdata only while idle; it is unchecked.
// Each item starts with the index math; a hint out of range ends there, a free
// hint slot is granted at once, and otherwise the words in use are scanned
// from word 0 for the first free slot, giving status 1 when all are full.
// The result shows on out_valid as the block returns to idle for the next transfer.
// The scan reads one bitmap word per cycle from the single RAM read
// port, so the word count in use sets the worst case.
// The result sits in an output register, so a stalled receiver holds it while
// the block runs the next item; that item waits at its end until the
// register drains. Reset clears the bitmap with a pass over all MAP_WORDS words,
// one word per cycle, during which in_stall stays high; config writes are
// still taken. words_in_use resets to 64.
module free_slot_bitmap_allocator #(
	parameter int MAP_WORDS = fsba_pkg::MAP_WORDS_DEF,
	parameter int WORD_BITS = fsba_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fsba_pkg::SLOT_W-1:0]     hint_slot,
	input  logic                            in_valid,
	output logic                            in_stall,
	output logic [fsba_pkg::SLOT_W-1:0]     granted_slot,
	output logic [fsba_pkg::STATUS_W-1:0]   status,
	output logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            cfg_we,
	input  logic [fsba_pkg::CFG_W-1:0]      cfg_wdata
);

	fsba_pkg::fsba_cmd_t cmd;
	fsba_pkg::fsba_sts_t sts;

	// sequencing: clear pass, index math, hint check, word scan, drain
	fsba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// bitmap storage, slot arithmetic and the output register
	fsba_dp #(
		.MAP_WORDS(MAP_WORDS),
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.hint_slot   (hint_slot),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.granted_slot(granted_slot),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
